// File: src/shs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// shs_pkg
// Shared types, constants and the block word builder for the SHA-1 stream
// hasher.
// ----------------------------------------------------------------------------
package shs_pkg;

   localparam int unsigned WORD_W       = 32;
   localparam int unsigned BLOCK_WORDS  = 16;
   localparam int unsigned ADDR_W       = 4;
   localparam int unsigned DIGEST_WORDS = 5;

   localparam logic [5:0] LENGTH_OFFSET = 6'd56;
   localparam logic [5:0] LAST_BYTE_POS = 6'd63;
   localparam logic [1:0] LAST_BYTE_LANE = 2'd3;
   localparam logic [3:0] LEN_HI_WORD   = 4'd14;
   localparam logic [3:0] LEN_LO_WORD   = 4'd15;
   localparam logic [7:0] PAD_BYTE      = 8'h80;
   localparam logic [2:0] LAST_WORD_IDX = 3'd4;

   localparam logic [6:0] SCHED_ROUNDS  = 7'd16;
   localparam logic [6:0] PHASE1_START  = 7'd20;
   localparam logic [6:0] PHASE2_START  = 7'd40;
   localparam logic [6:0] PHASE3_START  = 7'd60;
   localparam logic [6:0] FINAL_ROUND   = 7'd79;

   localparam logic [31:0] K_PHASE0 = 32'h5A827999;
   localparam logic [31:0] K_PHASE1 = 32'h6ED9EBA1;
   localparam logic [31:0] K_PHASE2 = 32'h8F1BBCDC;
   localparam logic [31:0] K_PHASE3 = 32'hCA62C1D6;

   typedef logic [DIGEST_WORDS-1:0][WORD_W-1:0] chain_type;

   // Element 0 sits in the low word.
   localparam chain_type SHA1_IV = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                    32'hEFCDAB89, 32'h67452301};

   typedef enum logic [1:0] {
      BLK_DATA,
      BLK_PAD,
      BLK_PAD_LEN,
      BLK_LEN
   } blk_kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_HASH,
      ST_FINISH
   } fsm_state_type;

   typedef struct packed {
      blk_kind_type kind;
      logic [5:0]   pos;
      logic [23:0]  acc;
      logic [63:0]  bit_len;
   } blk_ctx_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       end_of_message;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_payload_type;

   // Message word idx of the block being compressed, with padding and length
   // laid over the stored words as the block kind requires.
   function automatic logic [31:0] shs_build_word(logic [3:0] idx,
                                                  logic [31:0] ram_word,
                                                  blk_ctx_type ctx);
      logic [31:0] word;
      logic [31:0] pad_word;
      logic [31:0] acc_word;
      logic [3:0]  pw;
      logic [1:0]  pb;
      pw       = ctx.pos[5:2];
      pb       = ctx.pos[1:0];
      acc_word = {ctx.acc, 8'h00};
      pad_word = '0;
      for (int k = 0; k < 4; k++) begin
         if (2'(k) < pb) begin
            pad_word[31-8*k -: 8] = acc_word[31-8*k -: 8];
         end else if (2'(k) == pb) begin
            pad_word[31-8*k -: 8] = PAD_BYTE;
         end
      end
      word = '0;
      case (ctx.kind)
         BLK_DATA: begin
            word = ram_word;
         end
         BLK_PAD, BLK_PAD_LEN: begin
            if (idx < pw) begin
               word = ram_word;
            end else if (idx == pw) begin
               word = pad_word;
            end
            if (ctx.kind == BLK_PAD_LEN) begin
               if (idx == LEN_HI_WORD) word = ctx.bit_len[63:32];
               if (idx == LEN_LO_WORD) word = ctx.bit_len[31:0];
            end
         end
         BLK_LEN: begin
            if (idx == LEN_HI_WORD) word = ctx.bit_len[63:32];
            if (idx == LEN_LO_WORD) word = ctx.bit_len[31:0];
         end
         default: begin
            word = ram_word;
         end
      endcase
      return word;
   endfunction

endpackage
`default_nettype wire

// File: src/shs_block_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// shs_block_ram
// Message block store: 16 words of 32 bits, one write and one registered read
// per cycle.
// ----------------------------------------------------------------------------
module shs_block_ram (
   input  wire logic                        clock,
   input  wire logic                        wr_en,
   input  wire logic [shs_pkg::ADDR_W-1:0]  wr_addr,
   input  wire logic [shs_pkg::WORD_W-1:0]  wr_data,
   input  wire logic [shs_pkg::ADDR_W-1:0]  rd_addr,
   output      logic [shs_pkg::WORD_W-1:0]  rd_data
);

   logic [shs_pkg::WORD_W-1:0] mem [shs_pkg::BLOCK_WORDS];
   logic [shs_pkg::WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: src/shs_round_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// shs_round_core
// SHA-1 compression: one round per cycle over a 16-word schedule shift line,
// then a registered add folds the working words into the chaining words.
// ----------------------------------------------------------------------------
module shs_round_core (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic                        iv_load,
   input  wire shs_pkg::blk_ctx_type        ctx,
   output      logic [shs_pkg::ADDR_W-1:0]  rd_addr,
   input  wire logic [shs_pkg::WORD_W-1:0]  rd_data,
   output      logic                        done,
   output      shs_pkg::chain_type          chain
);

   logic        run_ff, run_in;
   logic        add_ff, add_in;
   logic        done_ff, done_in;
   logic [6:0]  t_ff, t_in;
   logic [31:0] a_ff, a_in, b_ff, b_in, c_ff, c_in, d_ff, d_in, e_ff, e_in;
   logic [31:0] w_ff [shs_pkg::BLOCK_WORDS];
   logic [31:0] w_in [shs_pkg::BLOCK_WORDS];
   shs_pkg::chain_type chain_ff, chain_in;

   logic [31:0] w_cur;
   logic [31:0] w_mix;
   logic [31:0] f_val;
   logic [31:0] k_val;
   logic [31:0] sum;

   always_comb begin
      w_mix = w_ff[2] ^ w_ff[7] ^ w_ff[13] ^ w_ff[15];
      if (t_ff < shs_pkg::SCHED_ROUNDS) begin
         w_cur = shs_pkg::shs_build_word(t_ff[3:0], rd_data, ctx);
      end else begin
         w_cur = {w_mix[30:0], w_mix[31]};
      end
      if (t_ff < shs_pkg::PHASE1_START) begin
         f_val = (b_ff & c_ff) | (~b_ff & d_ff);
         k_val = shs_pkg::K_PHASE0;
      end else if (t_ff < shs_pkg::PHASE2_START) begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = shs_pkg::K_PHASE1;
      end else if (t_ff < shs_pkg::PHASE3_START) begin
         f_val = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         k_val = shs_pkg::K_PHASE2;
      end else begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = shs_pkg::K_PHASE3;
      end
      sum = {a_ff[26:0], a_ff[31:27]} + f_val + e_ff + k_val + w_cur;
   end

   // Fetch one word ahead of the round that uses it.
   assign rd_addr = start ? '0 : t_ff[3:0] + 4'd1;

   always_comb begin
      run_in   = run_ff;
      add_in   = 1'b0;
      done_in  = 1'b0;
      t_in     = t_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      c_in     = c_ff;
      d_in     = d_ff;
      e_in     = e_ff;
      w_in     = w_ff;
      chain_in = chain_ff;
      if (start) begin
         run_in = 1'b1;
         t_in   = '0;
         a_in   = chain_ff[0];
         b_in   = chain_ff[1];
         c_in   = chain_ff[2];
         d_in   = chain_ff[3];
         e_in   = chain_ff[4];
      end else if (run_ff) begin
         a_in  = sum;
         b_in  = a_ff;
         c_in  = {b_ff[1:0], b_ff[31:2]};
         d_in  = c_ff;
         e_in  = d_ff;
         w_in[0] = w_cur;
         for (int i = 1; i < shs_pkg::BLOCK_WORDS; i++) begin
            w_in[i] = w_ff[i-1];
         end
         t_in = t_ff + 7'd1;
         if (t_ff == shs_pkg::FINAL_ROUND) begin
            run_in = 1'b0;
            add_in = 1'b1;
         end
      end
      if (add_ff) begin
         chain_in[0] = chain_ff[0] + a_ff;
         chain_in[1] = chain_ff[1] + b_ff;
         chain_in[2] = chain_ff[2] + c_ff;
         chain_in[3] = chain_ff[3] + d_ff;
         chain_in[4] = chain_ff[4] + e_ff;
         done_in     = 1'b1;
      end
      if (iv_load) begin
         chain_in = shs_pkg::SHA1_IV;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b0;
         add_ff   <= 1'b0;
         done_ff  <= 1'b0;
         t_ff     <= '0;
         chain_ff <= shs_pkg::SHA1_IV;
      end else begin
         run_ff   <= run_in;
         add_ff   <= add_in;
         done_ff  <= done_in;
         t_ff     <= t_in;
         chain_ff <= chain_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      c_ff <= c_in;
      d_ff <= d_in;
      e_ff <= e_in;
      w_ff <= w_in;
   end

   assign done  = done_ff;
   assign chain = chain_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> (!run_ff && !add_ff))
      else $error("compression started while a block is in flight");

   a_fold_after_last: assert property (@(posedge clock) disable iff (reset)
      (run_ff && t_ff == shs_pkg::FINAL_ROUND) |=> (add_ff && !run_ff))
      else $error("final round not followed by the chaining add");

   a_done_quiet: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (!run_ff && !add_ff))
      else $error("done raised while the core is still busy");

endmodule
`default_nettype wire

// File: src/sha1_stream_hasher.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sha1_stream_hasher
// Byte-stream SHA-1: packs bytes into a block store, compresses each full
// block, pads and appends the bit length at end of message and returns the
// five digest words.
//
//   port group   dir  payload            transfer when
//   req_*        in   req_payload_type   req_valid && !req_stall
//   rsp_*        out  rsp_payload_type   rsp_valid && !rsp_stall
//
// A byte is taken while the hasher is idle; the 64th byte of a block starts a
// compression (start and fetch, 80 rounds through the round core, fold and
// hand-back), and no further byte is taken until it is through.
// End of message adds one or two padding blocks, then the digest is copied
// into the output buffer and drains at one word per cycle unless stalled.
// A new message may start while the digest is still draining.
// Reset is synchronous and puts the chaining words back to the initial vector.
// ----------------------------------------------------------------------------
module sha1_stream_hasher (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output      logic                     req_stall,
   input  wire shs_pkg::req_payload_type req_payload,
   output      logic                     rsp_valid,
   input  wire logic                     rsp_stall,
   output      shs_pkg::rsp_payload_type rsp_payload
);

   shs_pkg::fsm_state_type state_ff, state_in;
   shs_pkg::blk_kind_type  kind_ff, kind_in;
   logic [5:0]   pos_ff, pos_in;
   logic [23:0]  acc_ff, acc_in;
   logic [63:0]  len_ff, len_in;
   logic         eom_ff, eom_in;
   logic         start_ff, start_in;
   logic         out_busy_ff, out_busy_in;
   logic [2:0]   out_idx_ff, out_idx_in;
   logic [31:0]  out_word_ff [shs_pkg::DIGEST_WORDS];
   logic [31:0]  out_word_in [shs_pkg::DIGEST_WORDS];

   logic         req_take;
   logic         rsp_take;
   logic [5:0]   pos_next;
   logic         iv_load;
   logic         wr_en;
   logic [shs_pkg::ADDR_W-1:0] rd_addr;
   logic [shs_pkg::WORD_W-1:0] rd_data;
   logic         core_done;
   shs_pkg::chain_type  core_chain;
   shs_pkg::blk_ctx_type ctx;

   assign req_stall = (state_ff != shs_pkg::ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = out_busy_ff && !rsp_stall;
   assign wr_en     = req_take && req_payload.byte_valid &&
                      (pos_ff[1:0] == shs_pkg::LAST_BYTE_LANE);
   assign ctx       = '{kind: kind_ff, pos: pos_ff, acc: acc_ff, bit_len: len_ff};

   shs_block_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (pos_ff[5:2]),
      .wr_data ({acc_ff, req_payload.data_byte}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   shs_round_core u_core (
      .clock   (clock),
      .reset   (reset),
      .start   (start_ff),
      .iv_load (iv_load),
      .ctx     (ctx),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .done    (core_done),
      .chain   (core_chain)
   );

   always_comb begin
      state_in    = state_ff;
      kind_in     = kind_ff;
      pos_in      = pos_ff;
      acc_in      = acc_ff;
      len_in      = len_ff;
      eom_in      = eom_ff;
      start_in    = 1'b0;
      iv_load     = 1'b0;
      out_busy_in = out_busy_ff;
      out_idx_in  = out_idx_ff;
      out_word_in = out_word_ff;
      pos_next    = pos_ff + {5'd0, req_payload.byte_valid};

      // Drain the digest one word per transfer.
      if (rsp_take) begin
         for (int i = 0; i < shs_pkg::DIGEST_WORDS - 1; i++) begin
            out_word_in[i] = out_word_ff[i+1];
         end
         out_idx_in = out_idx_ff + 3'd1;
         if (out_idx_ff == shs_pkg::LAST_WORD_IDX) begin
            out_busy_in = 1'b0;
            out_idx_in  = '0;
         end
      end

      case (state_ff)
         shs_pkg::ST_IDLE: begin
            if (req_take) begin
               if (req_payload.byte_valid) begin
                  case (pos_ff[1:0])
                     2'd0:    acc_in[23:16] = req_payload.data_byte;
                     2'd1:    acc_in[15:8]  = req_payload.data_byte;
                     2'd2:    acc_in[7:0]   = req_payload.data_byte;
                     default: acc_in        = acc_ff;
                  endcase
                  len_in = len_ff + 64'd8;
                  pos_in = pos_next;
               end
               if (req_payload.byte_valid && pos_ff == shs_pkg::LAST_BYTE_POS) begin
                  kind_in  = shs_pkg::BLK_DATA;
                  eom_in   = req_payload.end_of_message;
                  start_in = 1'b1;
                  state_in = shs_pkg::ST_HASH;
               end else if (req_payload.end_of_message) begin
                  kind_in  = (pos_next < shs_pkg::LENGTH_OFFSET) ?
                             shs_pkg::BLK_PAD_LEN : shs_pkg::BLK_PAD;
                  start_in = 1'b1;
                  state_in = shs_pkg::ST_HASH;
               end
            end
         end
         shs_pkg::ST_HASH: begin
            if (core_done) begin
               case (kind_ff)
                  shs_pkg::BLK_DATA: begin
                     if (eom_ff) begin
                        kind_in  = shs_pkg::BLK_PAD_LEN;
                        start_in = 1'b1;
                     end else begin
                        state_in = shs_pkg::ST_IDLE;
                     end
                  end
                  shs_pkg::BLK_PAD: begin
                     kind_in  = shs_pkg::BLK_LEN;
                     start_in = 1'b1;
                  end
                  default: begin
                     state_in = shs_pkg::ST_FINISH;
                  end
               endcase
            end
         end
         shs_pkg::ST_FINISH: begin
            // Hold until the previous digest has fully drained.
            if (!out_busy_ff) begin
               for (int i = 0; i < shs_pkg::DIGEST_WORDS; i++) begin
                  out_word_in[i] = core_chain[i];
               end
               out_busy_in = 1'b1;
               out_idx_in  = '0;
               iv_load     = 1'b1;
               pos_in      = '0;
               len_in      = '0;
               eom_in      = 1'b0;
               state_in    = shs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = shs_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= shs_pkg::ST_IDLE;
         kind_ff     <= shs_pkg::BLK_DATA;
         pos_ff      <= '0;
         len_ff      <= '0;
         eom_ff      <= 1'b0;
         start_ff    <= 1'b0;
         out_busy_ff <= 1'b0;
         out_idx_ff  <= '0;
      end else begin
         state_ff    <= state_in;
         kind_ff     <= kind_in;
         pos_ff      <= pos_in;
         len_ff      <= len_in;
         eom_ff      <= eom_in;
         start_ff    <= start_in;
         out_busy_ff <= out_busy_in;
         out_idx_ff  <= out_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      out_word_ff <= out_word_in;
   end

   assign rsp_valid               = out_busy_ff;
   assign rsp_payload.digest_word = out_word_ff[0];
   assign rsp_payload.word_index  = out_idx_ff;
   assign rsp_payload.last_word   = (out_idx_ff == shs_pkg::LAST_WORD_IDX);

   a_start_in_hash: assert property (@(posedge clock) disable iff (reset)
      start_ff |-> (state_ff == shs_pkg::ST_HASH))
      else $error("core started outside the hash state");

   a_done_in_hash: assert property (@(posedge clock) disable iff (reset)
      core_done |-> (state_ff == shs_pkg::ST_HASH))
      else $error("core finished a block nobody asked for");

   a_last_empties: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_payload.last_word) |=> !rsp_valid)
      else $error("digest buffer still busy after the last word");

endmodule
`default_nettype wire

// File: sim/sha1_stream_hasher_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sha1_stream_hasher_tb
// Self-checking bench for the byte-stream SHA-1 hasher. A short table of
// directed messages (empty message, "abc", byte extremes, empty items) is
// followed by random messages whose lengths cluster round the padding and
// block boundaries. Digests come from the table or a behavioural SHA-1 model,
// and each rsp transfer is checked against the oldest prediction. Both sides
// idle at random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module sha1_stream_hasher_tb;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned HOLD_CYCLES = 2000;
   localparam int unsigned DRAIN_CYCLES = 200;
   localparam int unsigned PHASE_ITEMS = 40;

   localparam logic [159:0] EMPTY_DIGEST = 160'hda39a3ee5e6b4b0d3255bfef95601890afd80709;
   localparam logic [159:0] ABC_DIGEST   = 160'ha9993e364706816aba3e25717850c26c9cd0d89d;

   typedef struct packed {
      shs_pkg::req_payload_type req;
      logic                     known;
      logic [159:0]             known_digest;
   } step_row_type;

   localparam int unsigned DIRECTED_ROWS = 16;

   // Rows with known set carry a digest that is well known; all other rows
   // are checked against the model below.
   localparam step_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{'{8'hA5, 1'b0, 1'b0}, 1'b0, 160'h0},          // empty item straight after reset
      '{'{8'h00, 1'b0, 1'b1}, 1'b1, EMPTY_DIGEST},    // empty message
      '{'{8'h61, 1'b1, 1'b0}, 1'b0, 160'h0},
      '{'{8'h62, 1'b1, 1'b0}, 1'b0, 160'h0},
      '{'{8'h63, 1'b1, 1'b1}, 1'b1, ABC_DIGEST},      // last byte rides on the end item
      '{'{8'h00, 1'b1, 1'b0}, 1'b0, 160'h0},
      '{'{8'hFF, 1'b1, 1'b0}, 1'b0, 160'h0},
      '{'{8'h3C, 1'b0, 1'b0}, 1'b0, 160'h0},          // empty item mid-message
      '{'{8'hFF, 1'b0, 1'b1}, 1'b0, 160'h0},          // end alone, data ignored
      '{'{8'hFF, 1'b1, 1'b1}, 1'b0, 160'h0},
      '{'{8'h00, 1'b1, 1'b1}, 1'b0, 160'h0},
      '{'{8'hFF, 1'b0, 1'b1}, 1'b1, EMPTY_DIGEST},
      '{'{8'h61, 1'b1, 1'b0}, 1'b0, 160'h0},
      '{'{8'h62, 1'b1, 1'b0}, 1'b0, 160'h0},
      '{'{8'h63, 1'b1, 1'b0}, 1'b0, 160'h0},
      '{'{8'h00, 1'b0, 1'b1}, 1'b1, ABC_DIGEST}       // end item after the last byte
   };

   localparam int unsigned BOUNDARY_LENGTHS [8] = '{55, 56, 57, 63, 64, 65, 119, 120};

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   shs_pkg::req_payload_type req_payload;
   logic                     rsp_valid;
   logic                     rsp_stall;
   shs_pkg::rsp_payload_type rsp_payload;

   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   bit          hold_request;
   int unsigned mismatches;
   int unsigned cycle_count;

   // model state
   logic [31:0] chain_q [shs_pkg::DIGEST_WORDS];
   logic [7:0]  msg_block [64];
   logic [5:0]  fill_pos;
   logic [63:0] bit_count;

   shs_pkg::rsp_payload_type digest_expect [$];
   shs_pkg::rsp_payload_type want_word;

   sha1_stream_hasher uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [31:0] rol32(logic [31:0] v, int unsigned n);
      return (v << n) | (v >> (32 - n));
   endfunction

   function automatic void sha1_restart();
      int i;
      for (i = 0; i < shs_pkg::DIGEST_WORDS; i++) chain_q[i] = shs_pkg::SHA1_IV[i];
      for (i = 0; i < 64; i++) msg_block[i] = 8'h00;
      fill_pos  = '0;
      bit_count = '0;
   endfunction

   function automatic void sha1_compress();
      logic [31:0] w [16];
      logic [31:0] a, b, c, d, e, f, k, wt, sum;
      int t;
      for (t = 0; t < 16; t++)
         w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
      a = chain_q[0];
      b = chain_q[1];
      c = chain_q[2];
      d = chain_q[3];
      e = chain_q[4];
      for (t = 0; t < 80; t++) begin
         if (t < 16) begin
            wt = w[t];
         end else begin
            wt = rol32(w[(t-3) & 15] ^ w[(t-8) & 15] ^ w[(t-14) & 15] ^ w[t & 15], 1);
            w[t & 15] = wt;
         end
         if (t < shs_pkg::PHASE1_START) begin
            f = (b & c) | (~b & d);
            k = shs_pkg::K_PHASE0;
         end else if (t < shs_pkg::PHASE2_START) begin
            f = b ^ c ^ d;
            k = shs_pkg::K_PHASE1;
         end else if (t < shs_pkg::PHASE3_START) begin
            f = (b & c) | (b & d) | (c & d);
            k = shs_pkg::K_PHASE2;
         end else begin
            f = b ^ c ^ d;
            k = shs_pkg::K_PHASE3;
         end
         sum = rol32(a, 5) + f + e + k + wt;
         e = d;
         d = c;
         c = rol32(b, 30);
         b = a;
         a = sum;
      end
      chain_q[0] += a;
      chain_q[1] += b;
      chain_q[2] += c;
      chain_q[3] += d;
      chain_q[4] += e;
   endfunction

   // Absorb one accepted item; return 1 with the digest when it ends a message.
   function automatic bit sha1_absorb(input shs_pkg::req_payload_type p,
                                      output logic [159:0] digest);
      int pos;
      int i;
      digest = '0;
      if (p.byte_valid) begin
         msg_block[fill_pos] = p.data_byte;
         bit_count += 64'd8;
         fill_pos++;
         if (fill_pos == 6'd0) sha1_compress();
      end
      if (!p.end_of_message) return 1'b0;
      pos = fill_pos;
      msg_block[pos] = shs_pkg::PAD_BYTE;
      pos++;
      // no room for the length: close this block and start another
      if (pos > shs_pkg::LENGTH_OFFSET) begin
         while (pos < 64) begin
            msg_block[pos] = 8'h00;
            pos++;
         end
         sha1_compress();
         pos = 0;
      end
      while (pos < shs_pkg::LENGTH_OFFSET) begin
         msg_block[pos] = 8'h00;
         pos++;
      end
      for (i = 0; i < 8; i++)
         msg_block[shs_pkg::LENGTH_OFFSET + i] = bit_count[63-8*i -: 8];
      sha1_compress();
      digest = {chain_q[0], chain_q[1], chain_q[2], chain_q[3], chain_q[4]};
      sha1_restart();
      return 1'b1;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
      mismatches++;
   endtask

   // Offer one item, wait for its transfer and queue the digest words it causes.
   task automatic offer(input shs_pkg::req_payload_type p, input logic known,
                        input logic [159:0] known_digest);
      logic [159:0] digest;
      shs_pkg::rsp_payload_type word;
      int i;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= p;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (sha1_absorb(p, digest)) begin
         if (known) digest = known_digest;
         for (i = 0; i < shs_pkg::DIGEST_WORDS; i++) begin
            word.digest_word = digest[159-32*i -: 32];
            word.word_index  = 3'(i);
            word.last_word   = (3'(i) == shs_pkg::LAST_WORD_IDX);
            digest_expect.push_back(word);
         end
      end
   endtask

   initial begin : receiver
      int unsigned hold_left;
      bit          hold_taken;
      hold_left  = 0;
      hold_taken = 1'b0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && !hold_taken) begin
            hold_left  = HOLD_CYCLES;
            hold_taken = 1'b1;
         end
         if (hold_left != 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (digest_expect.size() == 0) begin
            report_mismatch("unexpected digest word", rsp_payload.digest_word, 32'h0);
         end else begin
            want_word = digest_expect.pop_front();
            if (rsp_payload.digest_word !== want_word.digest_word)
               report_mismatch("digest_word", rsp_payload.digest_word, want_word.digest_word);
            if (rsp_payload.word_index !== want_word.word_index)
               report_mismatch("word_index", 32'(rsp_payload.word_index),
                               32'(want_word.word_index));
            if (rsp_payload.last_word !== want_word.last_word)
               report_mismatch("last_word", 32'(rsp_payload.last_word),
                               32'(want_word.last_word));
         end
      end
   end

   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count <= CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("sha1_stream_hasher_tb NOT OK");
      $finish;
   end

   initial begin : stimulus
      shs_pkg::req_payload_type p;
      int unsigned phase, len, n, items, messages;
      bit          carry_last;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_payload   <= '0;
      send_idle_pct  = 34;
      recv_idle_pct  = 55;
      hold_request   = 1'b0;
      mismatches     = 0;
      sha1_restart();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (n = 0; n < DIRECTED_ROWS; n++)
         offer(DIRECTED[n].req, DIRECTED[n].known, DIRECTED[n].known_digest);

      // long receiver hold while the sender keeps going, to back the block up
      hold_request = 1'b1;

      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 34;
               recv_idle_pct = 55;
            end
            1: begin
               send_idle_pct = 55;
               recv_idle_pct = 34;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         items    = 0;
         messages = 0;
         while (items < PHASE_ITEMS || messages < 3) begin
            case ($urandom_range(9))
               0, 1, 2, 3, 4: len = $urandom_range(8);
               5, 6, 7:       len = BOUNDARY_LENGTHS[$urandom_range(7)];
               default:       len = $urandom_range(70);
            endcase
            carry_last = ($urandom_range(1) == 1) && (len != 0);
            for (n = 0; n < len; n++) begin
               if ($urandom_range(9) == 0) begin
                  p.data_byte      = 8'($urandom);
                  p.byte_valid     = 1'b0;
                  p.end_of_message = 1'b0;
                  offer(p, 1'b0, '0);
               end
               p.data_byte      = 8'($urandom);
               p.byte_valid     = 1'b1;
               p.end_of_message = carry_last && (n == len - 1);
               offer(p, 1'b0, '0);
               items++;
            end
            if (!carry_last) begin
               p.data_byte      = 8'($urandom);
               p.byte_valid     = 1'b0;
               p.end_of_message = 1'b1;
               offer(p, 1'b0, '0);
               items++;
            end
            messages++;
         end
      end

      req_valid <= 1'b0;
      while (digest_expect.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("sha1_stream_hasher_tb OK");
      end else begin
         $display("sha1_stream_hasher_tb NOT OK");
      end
      $finish;
   end

endmodule
`default_nettype wire
